// ----- sv/u16u8_pkg.sv -----
// Shared types, constants and byte-encoding functions for the UTF-16 to UTF-8 encoder.
// No dependencies; used by the front, queue, back and top-level modules.
package u16u8_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [15:0] SURR_END       = 16'hE000;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [20:0] LIMIT_1BYTE    = 21'h00080;
    localparam logic [20:0] LIMIT_2BYTE    = 21'h00800;
    localparam logic [20:0] LIMIT_3BYTE    = 21'h10000;
    localparam logic [7:0]  LEAD_2BYTE     = 8'hC0;
    localparam logic [7:0]  LEAD_3BYTE     = 8'hE0;
    localparam logic [7:0]  LEAD_4BYTE     = 8'hF0;
    localparam logic [7:0]  CONT_BYTE      = 8'h80;
    localparam logic [5:0]  HIGH_SURR_TOP  = 6'b110110;

    // One request for the back end: an optional flushed lone high surrogate,
    // then an optional code point, and the end-of-string flag.
    typedef struct packed {
        logic        has_flush;
        logic [9:0]  flush_bits;
        logic        has_point;
        logic [20:0] point;
        logic        last;
    } cmd_t;

    // Index of the final byte of the encoding of cp (byte count minus one).
    function automatic logic [1:0] last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp < LIMIT_1BYTE) begin
            r = 2'd0;
        end else if (cp < LIMIT_2BYTE) begin
            r = 2'd1;
        end else if (cp < LIMIT_3BYTE) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    // Byte idx of the encoding of cp, given its final byte index li.
    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] li,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (li)
            2'd0: b = cp[7:0];
            2'd1: begin
                case (idx)
                    2'd0:    b = LEAD_2BYTE | {3'b000, cp[10:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            2'd2: begin
                case (idx)
                    2'd0:    b = LEAD_3BYTE | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = LEAD_4BYTE | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT_BYTE | {2'b00, cp[17:12]};
                    2'd2:    b = CONT_BYTE | {2'b00, cp[11:6]};
                    default: b = CONT_BYTE | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- sv/u16u8_front.sv -----
// Front end: accepts code units, pairs surrogates and builds requests.
// Depends on u16u8_pkg.
module u16u8_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [15:0]         code_unit,
    input  logic                end_of_string,
    output logic                cmd_valid,
    output u16u8_pkg::cmd_t     cmd
);

    logic       pending_valid_reg;
    logic       pending_valid_next;
    logic [9:0] pending_bits_reg;
    logic [9:0] pending_bits_next;
    logic       is_high;
    logic       is_low;
    logic       hold;

    assign is_high = (code_unit >= u16u8_pkg::HIGH_SURR_BASE)
                   && (code_unit < u16u8_pkg::LOW_SURR_BASE);
    assign is_low  = (code_unit >= u16u8_pkg::LOW_SURR_BASE)
                   && (code_unit < u16u8_pkg::SURR_END);
    assign hold    = is_high && !end_of_string;

    always_comb
    begin
        cmd.has_flush = 1'b0;
        cmd.flush_bits = pending_bits_reg;
        cmd.has_point = !hold;
        cmd.point = {5'b00000, code_unit};
        cmd.last = end_of_string;
        pending_valid_next = pending_valid_reg;
        pending_bits_next = pending_bits_reg;
        if (accept)
        begin
            pending_valid_next = hold;
            pending_bits_next = code_unit[9:0];
            if (pending_valid_reg && is_low)
            begin
                // pair complete: one supplementary code point
                cmd.has_point = 1'b1;
                cmd.point = u16u8_pkg::SUPP_BASE + {1'b0, pending_bits_reg, code_unit[9:0]};
                pending_valid_next = 1'b0;
            end
            else if (pending_valid_reg)
            begin
                cmd.has_flush = 1'b1;
            end
        end
    end

    assign cmd_valid = accept && (cmd.has_flush || cmd.has_point);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_bits_reg <= '0;
        end
        else
        begin
            pending_valid_reg <= pending_valid_next;
            pending_bits_reg <= pending_bits_next;
        end
    end

endmodule

// ----- sv/u16u8_queue.sv -----
// Short request queue between the front and back ends.
// Depends on u16u8_pkg; DEPTH must be at least 2.
module u16u8_queue
#(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  u16u8_pkg::cmd_t  wr_data,
    output logic             full,
    input  logic             rd_en,
    output u16u8_pkg::cmd_t  rd_data,
    output logic             empty
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    u16u8_pkg::cmd_t store [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_wr;
    logic            do_rd;

    assign full    = (count_reg == FullCnt);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/u16u8_back.sv -----
// Back end: walks each request byte by byte into a registered output stage.
// Depends on u16u8_pkg.
module u16u8_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_avail,
    input  u16u8_pkg::cmd_t  cmd,
    output logic             cmd_take,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       utf8_byte,
    output logic             run_last,
    output logic             string_done
);

    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        flush_done_reg;
    logic        flush_done_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic        run_last_reg;
    logic        done_reg;
    logic        in_flush;
    logic [20:0] cur_cp;
    logic [1:0]  cur_li;
    logic        cmd_end;
    logic        can_load;
    logic        step;

    assign in_flush = cmd.has_flush && !flush_done_reg;
    assign cur_cp   = in_flush ? {5'b00000, u16u8_pkg::HIGH_SURR_TOP, cmd.flush_bits}
                               : cmd.point;
    assign cur_li   = in_flush ? 2'd2 : u16u8_pkg::last_idx(cmd.point);
    assign cmd_end  = in_flush ? ((idx_reg == 2'd2) && !cmd.has_point) : (idx_reg == cur_li);
    assign can_load = !out_valid_reg || pop;
    assign step     = can_load && cmd_avail;
    assign cmd_take = step && cmd_end;

    always_comb
    begin
        idx_next = idx_reg;
        flush_done_next = flush_done_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            if (cmd_end)
            begin
                idx_next = '0;
                flush_done_next = 1'b0;
            end
            else if (in_flush && (idx_reg == 2'd2))
            begin
                // flushed surrogate sent, advance to the code point
                idx_next = '0;
                flush_done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            flush_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            flush_done_reg <= flush_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_reg <= u16u8_pkg::enc_byte(cur_cp, cur_li, idx_reg);
            run_last_reg <= cmd_end;
            done_reg <= cmd_end && cmd.last;
        end
    end

    assign empty       = !out_valid_reg;
    assign utf8_byte   = byte_reg;
    assign run_last    = run_last_reg;
    assign string_done = done_reg;

endmodule

// ----- sv/utf16_to_utf8_encoder_core.sv -----
// UTF-16 to UTF-8 encoder, top level. Depends on u16u8_pkg and the front, queue, back modules.
// Throughput: one output byte per cycle while requests are queued and pop drains the output;
// a unit causes up to 6 bytes (typically 1 to 3), all through the single byte-wide output
// register of the back end; a held high surrogate alone causes no byte.
// Reset (rst_n, asynchronous, active low) drops any held surrogate, queued request and
// waiting byte; the queue then starts empty, so units are accepted once reset is released.
module utf16_to_utf8_encoder_core
#(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  utf8_byte,
    output logic        run_last,
    output logic        string_done
);

    logic            accept;
    logic            q_full;
    logic            q_empty;
    logic            wr_en;
    logic            rd_en;
    u16u8_pkg::cmd_t wr_cmd;
    u16u8_pkg::cmd_t rd_cmd;

    // Hold off new units only while the request queue is full; a held high surrogate
    // writes nothing unless it flushes an earlier lone one, but is still accepted.
    assign full   = q_full;
    assign accept = push && !q_full;

    u16u8_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .cmd_valid     (wr_en),
        .cmd           (wr_cmd)
    );

    u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_cmd),
        .full    (q_full),
        .rd_en   (rd_en),
        .rd_data (rd_cmd),
        .empty   (q_empty)
    );

    // Drop the head request once its final byte enters the output register.
    u16u8_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (!q_empty),
        .cmd         (rd_cmd),
        .cmd_take    (rd_en),
        .empty       (empty),
        .pop         (pop),
        .utf8_byte   (utf8_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule
